### design/assu_pkg.sv
// Shared types, opcodes and constants for the alpha save/restore stack unit.
package assu_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam logic [15:0] Q_ONE           = 16'h8000;

  localparam logic [2:0] OP_BEGIN      = 3'd0;
  localparam logic [2:0] OP_MULTIPLY   = 3'd1;
  localparam logic [2:0] OP_SAVE       = 3'd2;
  localparam logic [2:0] OP_RESTORE    = 3'd3;
  localparam logic [2:0] OP_RESTORE_TO = 3'd4;
  localparam logic [2:0] OP_FILTER     = 3'd5;
  localparam logic [2:0] OP_GET        = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic exec;
    logic load_top;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_needed;
  } dp_status_t;

  function automatic logic [15:0] clamp_one(input logic [15:0] v);
    clamp_one = (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

### design/assu_ctrl.sv
// Controller state machine: input/output handshake and pop sequencing.
module assu_ctrl
  import assu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    accept        = in_valid && in_ready;
    state_nxt     = state_r;
    cmd.exec      = 1'b0;
    cmd.load_top  = 1'b0;
    cmd.out_load  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.exec = 1'b1;
          if (status.pop_needed) begin
            state_nxt = ST_LOAD;
          end else begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_top  = 1'b1;
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### design/assu_dp.sv
// Datapath: top-of-stack register, height, stack memory, multiplier and result register.
module assu_dp
  import assu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_alpha_value,
  input  logic [6:0]  in_target_count,
  input  logic [15:0] in_paint_alpha,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic [15:0] out_alpha_out,
  output logic        out_draw_enable,
  output logic [5:0]  out_prior_height,
  output logic        out_overflow
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned HW = $clog2(STACK_DEPTH + 1);
  localparam logic [HW-1:0] DEPTH_H = HW'(STACK_DEPTH);
  localparam logic [HW-1:0] ONE_H   = HW'(1);

  logic [15:0]   mem [STACK_DEPTH];
  logic [15:0]   rdata_r;
  logic [15:0]   top_r, top_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic [15:0]   init_alpha_r;

  logic [15:0]   alpha_r, alpha_nxt;
  logic          draw_r, draw_nxt;
  logic [5:0]    prior_r, prior_nxt;
  logic          ovf_r, ovf_nxt;

  logic [15:0]   factor, paint, mul_b;
  logic [31:0]   product;
  logic [15:0]   scaled;
  logic [HW-1:0] ht_m1, ht_m2;
  logic [HW+5:0] prior_ext;
  logic [HW+6:0] cnt_ext, ht_ext, cnt_m1;
  logic [6:0]    cnt_eff;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          pop_restore, pop_to;

  always_comb begin
    factor    = clamp_one(in_alpha_value);
    paint     = clamp_one(in_paint_alpha);
    mul_b     = (in_opcode == OP_FILTER) ? paint : factor;
    product   = top_r * mul_b;
    scaled    = product[30:15];
    ht_m1     = height_r - ONE_H;
    ht_m2     = height_r - HW'(2);
    prior_ext = {6'b0, ht_m1};
    cnt_eff   = (in_target_count == 7'd0) ? 7'd1 : in_target_count;
    cnt_ext   = {{HW{1'b0}}, cnt_eff};
    ht_ext    = {7'b0, height_r};
    cnt_m1    = cnt_ext - (HW+7)'(1);
    pop_restore = (in_opcode == OP_RESTORE) && (height_r > ONE_H);
    pop_to      = (in_opcode == OP_RESTORE_TO) && (cnt_ext < ht_ext);
    status.pop_needed = pop_restore || pop_to;
  end

  always_comb begin
    top_nxt    = top_r;
    height_nxt = height_r;
    wr_en      = 1'b0;
    wr_addr    = ht_m1[AW-1:0];
    rd_en      = 1'b0;
    rd_addr    = ht_m2[AW-1:0];
    alpha_nxt  = top_r;
    draw_nxt   = 1'b0;
    prior_nxt  = 6'd0;
    ovf_nxt    = 1'b0;
    if (cmd.load_top) begin
      top_nxt   = rdata_r;
      alpha_nxt = rdata_r;
    end else if (cmd.exec) begin
      unique case (in_opcode)
        OP_BEGIN: begin
          height_nxt = ONE_H;
          top_nxt    = clamp_one(init_alpha_r);
          alpha_nxt  = clamp_one(init_alpha_r);
        end
        OP_MULTIPLY: begin
          top_nxt   = scaled;
          alpha_nxt = scaled;
        end
        OP_SAVE: begin
          prior_nxt = prior_ext[5:0];
          if (height_r == DEPTH_H) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en      = 1'b1;
            height_nxt = height_r + ONE_H;
          end
        end
        OP_RESTORE: begin
          if (pop_restore) begin
            rd_en      = 1'b1;
            height_nxt = ht_m1;
          end
        end
        OP_RESTORE_TO: begin
          if (pop_to) begin
            rd_en      = 1'b1;
            rd_addr    = cnt_m1[AW-1:0];
            height_nxt = cnt_ext[HW-1:0];
          end
        end
        OP_FILTER: begin
          if (top_r >= Q_ONE) begin
            alpha_nxt = paint;
            draw_nxt  = 1'b1;
          end else if (top_r == 16'd0) begin
            alpha_nxt = paint;
          end else begin
            alpha_nxt = scaled;
            draw_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= Q_ONE;
      height_r     <= ONE_H;
      init_alpha_r <= Q_ONE;
    end else begin
      top_r    <= top_nxt;
      height_r <= height_nxt;
      if (cfg_wr_en) begin
        init_alpha_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      alpha_r <= alpha_nxt;
      draw_r  <= draw_nxt;
      prior_r <= prior_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_alpha_out    = alpha_r;
  assign out_draw_enable  = draw_r;
  assign out_prior_height = prior_r;
  assign out_overflow     = ovf_r;

endmodule

### design/alpha_save_restore_stack_unit.sv
// Top level of the alpha save/restore stack unit.
//
// Channel  Handshake               Payload
// in       in_valid / in_ready     opcode, alpha_value, target_count, paint_alpha
// out      out_valid / out_ready   alpha_out, draw_enable, prior_height, overflow
// cfg      cfg_wr_en               cfg_wr_data (initial_alpha)
//
// A new transfer is taken each cycle while the result register is free or being
// drained and no pop is loading. Restore and restore-to-count that pop pass
// through a load state, as the new top comes from the stack memory's registered
// read port. The top entry lives in a register, the rest in the memory.
// Reset is synchronous: height 1, top and initial_alpha 1.0; no clearing pass.
module alpha_save_restore_stack_unit
  import assu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_alpha_value,
  input  logic [6:0]  in_target_count,
  input  logic [15:0] in_paint_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_alpha_out,
  output logic        out_draw_enable,
  output logic [5:0]  out_prior_height,
  output logic        out_overflow
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assu_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_opcode        (in_opcode),
    .in_alpha_value   (in_alpha_value),
    .in_target_count  (in_target_count),
    .in_paint_alpha   (in_paint_alpha),
    .cmd              (cmd),
    .status           (status),
    .out_alpha_out    (out_alpha_out),
    .out_draw_enable  (out_draw_enable),
    .out_prior_height (out_prior_height),
    .out_overflow     (out_overflow)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for the opacity save/restore stack: queue-fed driver, predictor and result monitor.
module testbench;
  import assu_pkg::*;

  localparam logic [2:0] OP_NOP = 3'd7;
  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 235;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] factor;
    logic [6:0]  count;
    logic [15:0] paint;
  } stack_cmd_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic        draw;
    logic [5:0]  prior;
    logic        ovf;
  } stack_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode = OP_GET;
  logic [15:0] in_alpha_value = '0;
  logic [6:0]  in_target_count = '0;
  logic [15:0] in_paint_alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_alpha_out;
  logic        out_draw_enable;
  logic [5:0]  out_prior_height;
  logic        out_overflow;

  stack_cmd_t  command_q[$];
  stack_res_t  predicted_tops[$];
  logic [15:0] model_stack[DEPTH];
  int unsigned model_height = 1;
  logic [15:0] model_init_alpha = Q_ONE;
  int unsigned gen_height = 1;
  int unsigned gen_issued = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  bit          in_took = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_mask = '1;

  alpha_save_restore_stack_unit #(.STACK_DEPTH(DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_alpha_value   (in_alpha_value),
    .in_target_count  (in_target_count),
    .in_paint_alpha   (in_paint_alpha),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_alpha_out    (out_alpha_out),
    .out_draw_enable  (out_draw_enable),
    .out_prior_height (out_prior_height),
    .out_overflow     (out_overflow)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic stack_res_t apply_opacity_cmd(stack_cmd_t c);
    logic [15:0] factor;
    logic [15:0] paint;
    logic [15:0] top_val;
    logic [6:0]  cnt;
    logic [31:0] prod;
    stack_res_t  r;
    factor = (c.factor > Q_ONE) ? Q_ONE : c.factor;
    paint  = (c.paint > Q_ONE) ? Q_ONE : c.paint;
    r = '0;
    case (c.op)
      OP_BEGIN: begin
        model_height = 1;
        model_stack[0] = (model_init_alpha > Q_ONE) ? Q_ONE : model_init_alpha;
      end
      OP_MULTIPLY: begin
        prod = {16'd0, model_stack[model_height - 1]} * {16'd0, factor};
        model_stack[model_height - 1] = prod[30:15];
      end
      OP_SAVE: begin
        r.prior = 6'(model_height - 1);
        if (model_height >= DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          model_stack[model_height] = model_stack[model_height - 1];
          model_height++;
        end
      end
      OP_RESTORE: begin
        if (model_height > 1) model_height--;
      end
      OP_RESTORE_TO: begin
        cnt = (c.count == 7'd0) ? 7'd1 : c.count;
        if (cnt < model_height) model_height = cnt;
      end
      default: ;
    endcase
    top_val = model_stack[model_height - 1];
    r.alpha = top_val;
    if (c.op == OP_FILTER) begin
      if (top_val >= Q_ONE) begin
        r.alpha = paint;
        r.draw  = 1'b1;
      end else if (top_val == 16'd0) begin
        r.alpha = paint;
      end else begin
        prod = {16'd0, paint} * {16'd0, top_val};
        r.alpha = prod[30:15];
        r.draw  = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    $display("mismatch on %s at cycle %0d: expected %0d, got %0d", what, cycle_count, want,
             got);
  endtask

  always @(posedge clk) begin
    stack_res_t got;
    stack_res_t want;
    if (rst_n && cfg_wr_en) model_init_alpha = cfg_wr_data;
    if (rst_n && in_valid && in_ready) begin
      predicted_tops.push_back(apply_opacity_cmd(
          '{in_opcode, in_alpha_value, in_target_count, in_paint_alpha}));
      in_took = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{out_alpha_out, out_draw_enable, out_prior_height, out_overflow};
      if (predicted_tops.size() == 0) begin
        report_mismatch("unexpected transfer", 0, got.alpha);
      end else begin
        want = predicted_tops.pop_front();
        if (got.alpha != want.alpha) report_mismatch("alpha_out", want.alpha, got.alpha);
        if (got.draw != want.draw) report_mismatch("draw_enable", want.draw, got.draw);
        if (got.prior != want.prior) report_mismatch("prior_height", want.prior, got.prior);
        if (got.ovf != want.ovf) report_mismatch("overflow", want.ovf, got.ovf);
      end
    end
  end

  always @(negedge clk) begin
    stack_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold until the transfer completes
    end else begin
      in_took = 1'b0;
      if (gap_left > 0 || command_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        c = command_q.pop_front();
        in_opcode       <= c.op;
        in_alpha_value  <= c.factor;
        in_target_count <= c.count;
        in_paint_alpha  <= c.paint;
        in_valid        <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (cycle_count % 48 == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mask = 8'($urandom);
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= stall_mask[cycle_count % 8];
    endcase
  end

  task automatic add_cmd(logic [2:0] op, logic [15:0] factor, logic [6:0] count,
                         logic [15:0] paint);
    command_q.push_back('{op, factor, count, paint});
    gen_issued++;
    case (op)
      OP_BEGIN: gen_height = 1;
      OP_SAVE: if (gen_height < DEPTH) gen_height++;
      OP_RESTORE: if (gen_height > 1) gen_height--;
      OP_RESTORE_TO: begin
        if (count == 7'd0) gen_height = 1;
        else if (count < gen_height) gen_height = count;
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_factor();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return Q_ONE;
      2: return 16'($urandom_range(32769, 65535));
      3: return 16'($urandom);
      default: return 16'($urandom_range(26000, 32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_paint();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return Q_ONE;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic fill_stack();
    while (gen_height < DEPTH) begin
      if ($urandom_range(0, 4) == 0)
        add_cmd(OP_MULTIPLY, pick_factor(), 7'($urandom), pick_paint());
      else
        add_cmd(OP_SAVE, 16'($urandom), 7'($urandom), 16'($urandom));
    end
    repeat ($urandom_range(1, 3)) add_cmd(OP_SAVE, 16'($urandom), 7'($urandom), 16'($urandom));
    add_cmd(OP_FILTER, 16'($urandom), 7'($urandom), pick_paint());
    add_cmd(OP_RESTORE_TO, 16'($urandom), 7'($urandom_range(0, DEPTH + 2)), 16'($urandom));
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned base;
    int unsigned r;
    logic [2:0]  op;
    logic [6:0]  cnt;
    base = gen_issued;
    add_cmd(OP_BEGIN, 16'($urandom), 7'($urandom), 16'($urandom));
    while (gen_issued - base < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(4, 30)) begin
          r = $urandom_range(0, 99);
          op = (r < 26) ? OP_SAVE : (r < 44) ? OP_MULTIPLY : (r < 54) ? OP_RESTORE :
               (r < 64) ? OP_RESTORE_TO : (r < 84) ? OP_FILTER : (r < 92) ? OP_GET :
               (r < 95) ? OP_BEGIN : OP_NOP;
          cnt = (op == OP_RESTORE_TO && $urandom_range(0, 3) != 0) ?
                7'($urandom_range(0, gen_height + 1)) : 7'($urandom);
          add_cmd(op, pick_factor(), cnt, pick_paint());
        end
      end else if (r < 70) begin
        fill_stack();
      end else if (r < 85) begin
        repeat ($urandom_range(2, 12))
          add_cmd(($urandom_range(0, 2) == 0) ? OP_FILTER : OP_RESTORE, 16'($urandom),
                  7'($urandom), pick_paint());
      end else begin
        repeat ($urandom_range(2, 10))
          add_cmd(3'($urandom_range(0, 7)), 16'($urandom), 7'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (command_q.size() != 0 || in_valid || predicted_tops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_init_alpha(logic [15:0] value);
    @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [15:0] phase_cfg[8];
    model_stack[0] = Q_ONE;
    phase_cfg = '{Q_ONE, 16'd0, 16'hFFFF, 16'd1, 16'h7FFF, 16'h4000, 16'($urandom), 16'h8001};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (phase_cfg[p]) begin
      write_init_alpha(phase_cfg[p]);
      if (p == 0) begin
        add_cmd(OP_GET, 16'hFFFF, 7'h7F, 16'hFFFF);
        add_cmd(OP_FILTER, 16'd0, 7'd0, 16'hFFFF);
        add_cmd(OP_RESTORE, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_RESTORE_TO, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_SAVE, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_MULTIPLY, 16'hFFFF, 7'd0, 16'd0);
        add_cmd(OP_MULTIPLY, 16'h4000, 7'd0, 16'd0);
        add_cmd(OP_FILTER, 16'd0, 7'd0, Q_ONE);
        add_cmd(OP_FILTER, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_SAVE, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_RESTORE_TO, 16'd0, 7'h7F, 16'd0);
        add_cmd(OP_RESTORE_TO, 16'd0, 7'd3, 16'd0);
        add_cmd(OP_MULTIPLY, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_FILTER, 16'd0, 7'd0, 16'd12345);
        add_cmd(OP_RESTORE, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_NOP, 16'hFFFF, 7'h7F, 16'hFFFF);
        add_cmd(OP_MULTIPLY, 16'd1, 7'd0, 16'd0);
        add_cmd(OP_BEGIN, 16'd0, 7'd0, 16'd0);
        add_cmd(OP_MULTIPLY, 16'h7FFF, 7'd0, 16'd0);
        add_cmd(OP_FILTER, 16'd0, 7'd0, 16'hFFFF);
        add_cmd(OP_GET, 16'd0, 7'd0, 16'd0);
        fill_stack();
      end
      run_phase(ITEMS_PER_PHASE);
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
